@@ src/phcv_pkg.sv @@
package phcv_pkg;

   // Verdict codes carried in the result item.
   localparam logic [1:0] VERDICT_OK         = 2'd0;
   localparam logic [1:0] VERDICT_LENGTH_ERR = 2'd1;
   localparam logic [1:0] VERDICT_FORMAT_ERR = 2'd2;

   // Configuration register indexes.
   localparam int unsigned CSR_INDEX_W = 1;
   localparam logic [CSR_INDEX_W-1:0] CSR_SERVICE_ID    = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ALLOWED_FLAGS = 1'd1;

   // Fixed header values and CRC-16/CCITT-FALSE constants.
   localparam logic [7:0]  HDR_SYNC    = 8'haa;
   localparam logic [7:0]  HDR_TYPE    = 8'h21;
   localparam logic [7:0]  HDR_VERSION = 8'h01;
   localparam logic [7:0]  HDR_ZERO    = 8'h00;
   localparam logic [15:0] CRC_INIT    = 16'hffff;
   localparam logic [15:0] CRC_POLY    = 16'h1021;
   localparam int unsigned MIN_PACKET  = 11;
   localparam int unsigned LEN_OUT_MAX = 511;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_item_type;

   typedef struct packed {
      logic [1:0] verdict;
      logic [7:0] sequence_number;
      logic [7:0] flag_bits;
      logic [8:0] packet_length;
   } rsp_item_type;

   // One byte through the CRC, MSB first, unrolled over the eight bits.
   function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] acc;
      acc = crc ^ {b, 8'h00};
      for (int k = 0; k < 8; k++) begin
         acc = acc[15] ? ({acc[14:0], 1'b0} ^ CRC_POLY) : {acc[14:0], 1'b0};
      end
      return acc;
   endfunction

endpackage

@@ src/packet_header_crc_validator.sv @@
// A verdict is registered in the result register as its packet's last byte leaves the input register.
// Throughput: one byte per cycle; the input register feeds a single combinational pass
// (header checks and a byte-wide CRC step) into the result register.
// The input stalls only while a last byte waits behind a result not yet taken.
// Reset is synchronous: it clears the pipeline, the packet state and both registers.
module packet_header_crc_validator
   import phcv_pkg::*;
#(
   parameter int unsigned MAX_PACKET_BYTES = 511
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  req_item_type           req_item,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output rsp_item_type           rsp_item,
   input  logic                   csr_write,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [7:0]             csr_wdata
);

   localparam int unsigned CNT_W = $clog2(MAX_PACKET_BYTES + 1);
   localparam int unsigned LW    = (CNT_W > 9) ? CNT_W : 9;
   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_PACKET_BYTES);

   // Configuration registers.
   logic [7:0] service_id_ff;
   logic [7:0] allowed_flags_ff;

   // Input register.
   logic         s1_valid_ff, s1_valid_in;
   req_item_type s1_item_ff;

   // Per-packet state.
   logic [CNT_W-1:0] byte_index_ff, byte_index_in;
   logic [15:0]      crc_ff, crc_in;
   logic [7:0]       delay0_ff, delay0_in;
   logic [7:0]       delay1_ff, delay1_in;
   logic [7:0]       declared_ff, declared_in;
   logic             header_good_ff, header_good_in;
   logic [7:0]       seq_ff, seq_in;
   logic [7:0]       flag_ff, flag_in;

   // Result register.
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_item_type rsp_item_ff, rsp_item_in;

   logic          s1_advance;
   logic          s1_fire;
   logic          s1_last;
   logic [7:0]    b;
   logic [LW-1:0] pos;
   logic [LW-1:0] len;
   logic [LW-1:0] declared_ext;
   logic [15:0]   trailing;

   assign s1_last    = s1_item_ff.last_byte;
   assign b          = s1_item_ff.data_byte;
   assign s1_advance = !s1_last || !rsp_valid_ff || rsp_ready;
   assign s1_fire    = s1_valid_ff && s1_advance;
   assign req_ready  = !s1_valid_ff || s1_advance;
   assign s1_valid_in = req_ready ? req_valid : s1_valid_ff;

   // Configuration writes; an index beyond the list is dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         service_id_ff    <= '0;
         allowed_flags_ff <= '0;
      end else if (csr_write) begin
         case (csr_index)
            CSR_SERVICE_ID:    service_id_ff    <= csr_wdata;
            CSR_ALLOWED_FLAGS: allowed_flags_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Single pass over one byte: count, header checks, CRC and verdict.
   always_comb begin
      pos            = LW'(byte_index_ff);
      byte_index_in  = (byte_index_ff < CNT_MAX) ? byte_index_ff + 1'b1 : byte_index_ff;
      len            = LW'(byte_index_in);
      header_good_in = header_good_ff;
      seq_in         = seq_ff;
      declared_in    = declared_ff;
      flag_in        = flag_ff;
      crc_in         = crc_ff;

      case (pos)
         LW'(0): if (b != HDR_SYNC) header_good_in = 1'b0;
         LW'(1): if (b != HDR_TYPE) header_good_in = 1'b0;
         LW'(2): seq_in = b;
         LW'(3): declared_in = b;
         LW'(4): if (b != HDR_VERSION) header_good_in = 1'b0;
         LW'(5): if (b != HDR_VERSION) header_good_in = 1'b0;
         LW'(6): if (b != service_id_ff) header_good_in = 1'b0;
         LW'(7): if (b != HDR_ZERO) header_good_in = 1'b0;
         LW'(8): begin
            flag_in = b;
            if ((b & ~allowed_flags_ff) != 8'h00) header_good_in = 1'b0;
         end
         default: ;
      endcase

      // The byte two places back joins the sum once it is byte 8 or later.
      if (pos >= LW'(10)) begin
         crc_in = crc_feed(crc_ff, delay1_ff);
      end
      trailing  = {b, delay0_ff};
      delay1_in = delay0_ff;
      delay0_in = b;

      declared_ext = LW'(declared_in);
      rsp_item_in.sequence_number = seq_in;
      rsp_item_in.flag_bits       = flag_in;
      rsp_item_in.packet_length   = (len > LW'(LEN_OUT_MAX)) ? 9'(LEN_OUT_MAX) : len[8:0];
      if (byte_index_in >= CNT_MAX || len < LW'(MIN_PACKET)
          || declared_ext != len - LW'(8)) begin
         rsp_item_in.verdict = VERDICT_LENGTH_ERR;
      end else if (!header_good_in || crc_in != trailing) begin
         rsp_item_in.verdict = VERDICT_FORMAT_ERR;
      end else begin
         rsp_item_in.verdict = VERDICT_OK;
      end

      // A result appears for a last byte; a waiting result leaves when taken.
      if (s1_fire && s1_last) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         byte_index_ff  <= '0;
         crc_ff         <= CRC_INIT;
         delay0_ff      <= '0;
         delay1_ff      <= '0;
         declared_ff    <= '0;
         header_good_ff <= 1'b1;
         seq_ff         <= '0;
         flag_ff        <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (s1_fire) begin
            if (s1_last) begin
               byte_index_ff  <= '0;
               crc_ff         <= CRC_INIT;
               delay0_ff      <= '0;
               delay1_ff      <= '0;
               declared_ff    <= '0;
               header_good_ff <= 1'b1;
               seq_ff         <= '0;
               flag_ff        <= '0;
            end else begin
               byte_index_ff  <= byte_index_in;
               crc_ff         <= crc_in;
               delay0_ff      <= delay0_in;
               delay1_ff      <= delay1_in;
               declared_ff    <= declared_in;
               header_good_ff <= header_good_in;
               seq_ff         <= seq_in;
               flag_ff        <= flag_in;
            end
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         s1_item_ff <= req_item;
      end
      if (s1_fire && s1_last) begin
         rsp_item_ff <= rsp_item_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   // A new result only follows a last byte leaving the input register.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(s1_fire && s1_last))
      else $error("result raised without a last byte");

   // The packet state is cleared after each verdict.
   assert property (@(posedge clock) disable iff (reset)
      (s1_fire && s1_last) |=> (byte_index_ff == '0 && crc_ff == CRC_INIT && header_good_ff))
      else $error("packet state not cleared after verdict");

   // The input only stalls behind a last byte blocked by an untaken result.
   assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (s1_valid_ff && s1_last && rsp_valid_ff && !rsp_ready))
      else $error("input stalled without cause");

   // A good verdict implies at least the minimum packet length.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_item_ff.verdict == VERDICT_OK)
         |-> (rsp_item_ff.packet_length >= 9'(MIN_PACKET)))
      else $error("good verdict on a short packet");

endmodule
